// File: hdl/cfb_pkg.sv
// Shared types, operation codes and flag positions for the 16-bit ALU with
// NZVC flags and branch resolution. No dependencies.
package cfb_pkg;

  localparam int WORD_WIDTH = 16;
  localparam int PC_WIDTH   = 16;
  localparam int OP_WIDTH   = 6;
  localparam int IMM_WIDTH  = 8;
  localparam int FLAG_WIDTH = 4;

  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_V = 1;
  localparam int FLAG_C = 0;

  localparam logic [OP_WIDTH-1:0] OP_BR  = 6'd0;
  localparam logic [OP_WIDTH-1:0] OP_BNE = 6'd1;
  localparam logic [OP_WIDTH-1:0] OP_BEQ = 6'd2;
  localparam logic [OP_WIDTH-1:0] OP_BPL = 6'd3;
  localparam logic [OP_WIDTH-1:0] OP_BMI = 6'd4;
  localparam logic [OP_WIDTH-1:0] OP_BVC = 6'd5;
  localparam logic [OP_WIDTH-1:0] OP_BVS = 6'd6;
  localparam logic [OP_WIDTH-1:0] OP_BCC = 6'd7;
  localparam logic [OP_WIDTH-1:0] OP_BCS = 6'd8;
  localparam logic [OP_WIDTH-1:0] OP_BGE = 6'd9;
  localparam logic [OP_WIDTH-1:0] OP_BLT = 6'd10;
  localparam logic [OP_WIDTH-1:0] OP_BGT = 6'd11;
  localparam logic [OP_WIDTH-1:0] OP_BLE = 6'd12;
  localparam logic [OP_WIDTH-1:0] OP_BHI = 6'd13;
  localparam logic [OP_WIDTH-1:0] OP_BLS = 6'd14;
  localparam logic [OP_WIDTH-1:0] OP_CLR = 6'd15;
  localparam logic [OP_WIDTH-1:0] OP_NOT = 6'd16;
  localparam logic [OP_WIDTH-1:0] OP_INC = 6'd17;
  localparam logic [OP_WIDTH-1:0] OP_DEC = 6'd18;
  localparam logic [OP_WIDTH-1:0] OP_NEG = 6'd19;
  localparam logic [OP_WIDTH-1:0] OP_TST = 6'd20;
  localparam logic [OP_WIDTH-1:0] OP_ROR = 6'd21;
  localparam logic [OP_WIDTH-1:0] OP_ROL = 6'd22;
  localparam logic [OP_WIDTH-1:0] OP_ASR = 6'd23;
  localparam logic [OP_WIDTH-1:0] OP_ASL = 6'd24;
  localparam logic [OP_WIDTH-1:0] OP_ADC = 6'd25;
  localparam logic [OP_WIDTH-1:0] OP_SBC = 6'd26;
  localparam logic [OP_WIDTH-1:0] OP_MOV = 6'd27;
  localparam logic [OP_WIDTH-1:0] OP_ADD = 6'd28;
  localparam logic [OP_WIDTH-1:0] OP_SUB = 6'd29;
  localparam logic [OP_WIDTH-1:0] OP_CMP = 6'd30;
  localparam logic [OP_WIDTH-1:0] OP_AND = 6'd31;
  localparam logic [OP_WIDTH-1:0] OP_OR  = 6'd32;
  localparam logic [OP_WIDTH-1:0] OP_CCC = 6'd33;
  localparam logic [OP_WIDTH-1:0] OP_SCC = 6'd34;
  localparam logic [OP_WIDTH-1:0] OP_SOB = 6'd35;

  typedef struct packed {
    logic [OP_WIDTH-1:0]         op;
    logic [15:0]                 operand_a;
    logic [15:0]                 operand_b;
    logic signed [IMM_WIDTH-1:0] small_immediate;
    logic [PC_WIDTH-1:0]         pc_in;
  } cfb_cmd_t;

  typedef struct packed {
    logic [15:0]           result_word;
    logic [FLAG_WIDTH-1:0] flags_out;
    logic                  branch_taken;
    logic [PC_WIDTH-1:0]   next_pc;
  } cfb_res_t;

endpackage

// File: hdl/cfb_cmd_if.sv
// Valid/ready channel that carries one ALU command item.
// Depends on cfb_pkg for the payload type.
interface cfb_cmd_if;
  logic              valid;
  logic              ready;
  cfb_pkg::cfb_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/cfb_res_if.sv
// Valid/ready channel that carries one ALU result item.
// Depends on cfb_pkg for the payload type.
interface cfb_res_if;
  logic              valid;
  logic              ready;
  cfb_pkg::cfb_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/cpu16_alu_flags_branch.sv
// Throughput: one item per cycle while res.ready is high; the input register,
// the ALU and flag logic, and the result register form a two-stage pipeline
// with the flag register updated as each item enters the result register.
// Reset (rst, synchronous, active high) clears both stage valid bits and
// the NZVC flags.
module cpu16_alu_flags_branch (
  input  logic        clk,
  input  logic        rst,
  cfb_cmd_if.sink     cmd,
  cfb_res_if.source   res
);
  import cfb_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0] W_ONE  = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] W_ONES = {W{1'b1}};
  localparam logic [W-1:0] W_SIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] W_SMAX = {1'b0, {(W-1){1'b1}}};

  logic                  s1_valid;
  cfb_cmd_t              s1;
  logic                  out_valid;
  cfb_res_t              out_data;
  logic [FLAG_WIDTH-1:0] flags;
  logic                  adv;

  logic [63:0]           a64, b64, r64;
  logic [W-1:0]          a_w, b_w, r_w;
  logic [W:0]            add_s, sub_ba, sub_ab;
  logic [PC_WIDTH-1:0]   off;
  logic                  n, z, v, c, cin, cond;
  logic [FLAG_WIDTH-1:0] fl;
  logic                  taken;
  logic [PC_WIDTH-1:0]   npc;
  logic [W-1:0]          inc_r, dec_r, sh_r;
  logic                  sh_c;

  function automatic logic [1:0] nz_of(input logic [W-1:0] r);
    return {r[W-1], r == '0};
  endfunction

  assign adv       = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || adv;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  assign a64 = {48'b0, s1.operand_a};
  assign b64 = {48'b0, s1.operand_b};
  assign a_w = a64[W-1:0];
  assign b_w = b64[W-1:0];
  assign off = {{(PC_WIDTH-IMM_WIDTH){s1.small_immediate[IMM_WIDTH-1]}}, s1.small_immediate};

  assign n   = flags[FLAG_N];
  assign z   = flags[FLAG_Z];
  assign v   = flags[FLAG_V];
  assign c   = flags[FLAG_C];
  assign cin = c;

  assign add_s  = {1'b0, b_w} + {1'b0, a_w};
  assign sub_ba = {1'b0, b_w} - {1'b0, a_w};
  assign sub_ab = {1'b0, a_w} - {1'b0, b_w};
  assign inc_r  = b_w + W_ONE;
  assign dec_r  = b_w - W_ONE;

  always_comb begin
    case (s1.op)
      OP_BR:   cond = 1'b1;
      OP_BNE:  cond = !z;
      OP_BEQ:  cond = z;
      OP_BPL:  cond = !n;
      OP_BMI:  cond = n;
      OP_BVC:  cond = !v;
      OP_BVS:  cond = v;
      OP_BCC:  cond = !c;
      OP_BCS:  cond = c;
      OP_BGE:  cond = n == v;
      OP_BLT:  cond = n != v;
      OP_BGT:  cond = (n == v) && !z;
      OP_BLE:  cond = (n != v) || z;
      OP_BHI:  cond = !c && !z;
      OP_BLS:  cond = c || z;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    case (s1.op)
      OP_ROR:  begin sh_c = b_w[0];   sh_r = {b_w[0], b_w[W-1:1]};   end
      OP_ROL:  begin sh_c = b_w[W-1]; sh_r = {b_w[W-2:0], b_w[W-1]}; end
      OP_ASR:  begin sh_c = b_w[0];   sh_r = {b_w[W-1], b_w[W-1:1]}; end
      default: begin sh_c = b_w[W-1]; sh_r = {b_w[W-2:0], 1'b0};     end
    endcase
  end

  always_comb begin
    r_w   = b_w;
    fl    = flags;
    taken = 1'b0;
    npc   = s1.pc_in;
    case (s1.op)
      OP_CLR: begin
        r_w = '0;
        fl  = 4'b0100;
      end
      OP_NOT: begin
        r_w = ~b_w;
        fl  = {nz_of(~b_w), 1'b0, 1'b1};
      end
      OP_INC: begin
        r_w = inc_r;
        fl  = {nz_of(inc_r), b_w == W_SMAX, b_w == W_ONES};
      end
      OP_DEC: begin
        r_w = dec_r;
        fl  = {nz_of(dec_r), b_w == W_SIGN, b_w == '0};
      end
      OP_NEG: begin
        r_w = '0 - b_w;
        fl  = {nz_of('0 - b_w), b_w == W_SIGN, b_w != '0};
      end
      OP_TST: begin
        fl = {nz_of(b_w), 2'b00};
      end
      OP_ROR, OP_ROL, OP_ASR, OP_ASL: begin
        r_w = sh_r;
        fl  = {nz_of(sh_r), sh_r[W-1] ^ sh_c, sh_c};
      end
      OP_ADC: begin
        r_w = b_w + {{(W-1){1'b0}}, cin};
        fl  = {nz_of(b_w + {{(W-1){1'b0}}, cin}), cin && (b_w == W_SMAX),
               cin && (b_w == W_ONES)};
      end
      OP_SBC: begin
        r_w = b_w - {{(W-1){1'b0}}, cin};
        fl  = {nz_of(b_w - {{(W-1){1'b0}}, cin}), cin && (b_w == W_SIGN),
               cin && (b_w == '0)};
      end
      OP_MOV: begin
        r_w = a_w;
        fl  = {nz_of(a_w), 1'b0, cin};
      end
      OP_ADD: begin
        r_w = add_s[W-1:0];
        fl  = {nz_of(add_s[W-1:0]),
               (b_w[W-1] ^ add_s[W-1]) & (a_w[W-1] ^ add_s[W-1]), add_s[W]};
      end
      OP_SUB: begin
        r_w = sub_ba[W-1:0];
        fl  = {nz_of(sub_ba[W-1:0]),
               (b_w[W-1] ^ a_w[W-1]) & (b_w[W-1] ^ sub_ba[W-1]), sub_ba[W]};
      end
      OP_CMP: begin
        fl = {nz_of(sub_ab[W-1:0]),
              (a_w[W-1] ^ b_w[W-1]) & (a_w[W-1] ^ sub_ab[W-1]), sub_ab[W]};
      end
      OP_AND: begin
        r_w = a_w & b_w;
        fl  = {nz_of(a_w & b_w), 1'b0, cin};
      end
      OP_OR: begin
        r_w = a_w | b_w;
        fl  = {nz_of(a_w | b_w), 1'b0, cin};
      end
      OP_CCC: begin
        fl = flags & ~s1.small_immediate[FLAG_WIDTH-1:0];
      end
      OP_SCC: begin
        fl = flags | s1.small_immediate[FLAG_WIDTH-1:0];
      end
      OP_SOB: begin
        r_w = dec_r;
        if (dec_r != '0) begin
          taken = 1'b1;
          npc   = s1.pc_in - off;
        end
      end
      default: begin
        if (s1.op <= OP_BLS && cond) begin
          taken = 1'b1;
          npc   = s1.pc_in + off;
        end
      end
    endcase
  end

  assign r64 = 64'(r_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        flags     <= fl;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1 <= cmd.data;
    end
    if (adv) begin
      out_data.result_word  <= r64[15:0];
      out_data.flags_out    <= fl;
      out_data.branch_taken <= taken;
      out_data.next_pc      <= npc;
    end
  end

`ifndef SYNTHESIS
  a_flags_match_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> res.data.flags_out == flags)
    else $error("result flags differ from the flag register");

  a_no_taken_for_alu_ops: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.op >= OP_CLR && s1.op < OP_SOB |-> !taken)
    else $error("non-branch operation marked as taken");

  a_flags_cleared_by_reset: assert property (@(posedge clk)
    rst |=> flags == '0 && !out_valid && !s1_valid)
    else $error("state not cleared by reset");

  a_stall_holds_input_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("input stage lost an item during a stall");
`endif

endmodule
